/* hdl/rc16_pkg.sv */
// Shared widths and constants for the 16-bit recurrence checksum.
// No dependencies; compile first.
`default_nettype none

package rc16_pkg;

	localparam int DATA_W = 8;
	localparam int IDX_W  = 8;
	localparam int TERM_W = 16;

	// Terms live modulo 2^16 - 1.
	localparam logic [TERM_W-1:0] MODULUS     = 16'hFFFF;
	localparam logic [TERM_W-1:0] TERM_ONE    = 16'd1;
	localparam logic [TERM_W-1:0] SEED_OFFSET = 16'd7;
	localparam logic [IDX_W-1:0]  ALPHA_MUL   = 8'd17;
	localparam logic [IDX_W-1:0]  BETA_MUL    = 8'd31;
	localparam logic [IDX_W-1:0]  IDX_FIRST   = 8'd1;

endpackage

`default_nettype wire

/* hdl/rc16_byte_if.sv */
// Request channel carrying one message byte and its last-byte mark.
// Depends on rc16_pkg.
`default_nettype none

interface rc16_byte_if import rc16_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* hdl/rc16_sum_if.sv */
// Result channel carrying the final checksum of a message.
// Depends on rc16_pkg.
`default_nettype none

interface rc16_sum_if import rc16_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TERM_W-1:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink   (input valid, input checksum, output ready);
endinterface

`default_nettype wire

/* hdl/recurrence_checksum_16_top.sv */
// Top level of the 16-bit recurrence checksum: input register, term state, result register.
// Depends on rc16_pkg, rc16_byte_if, rc16_sum_if, rc16_term.
//
//   channel | dir | payload               | transfer
//   in_ch   | in  | data_byte, last_byte  | valid & ready
//   out_ch  | out | checksum              | valid & ready, one per last byte
//
// One byte per cycle sustained. The term update (products plus modulo fold, fed
// back through the term registers) works on the byte held in the input register
// and completes in that cycle; the checksum is registered as the last byte leaves
// the input register. Reset arms the block for a new message and empties both
// registers. A held result stalls input only when a second last byte reaches it.
`default_nettype none

module recurrence_checksum_16_top import rc16_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	rc16_byte_if.sink          in_ch,
	rc16_sum_if.source         out_ch
);

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              last_s1;

	logic              first_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TERM_W-1:0] older_q;
	logic [TERM_W-1:0] cur_q;

	logic              out_valid_q;
	logic [TERM_W-1:0] checksum_q;

	logic              advance;
	logic [TERM_W-1:0] term;
	logic [TERM_W-1:0] new_cur;
	logic [TERM_W-1:0] new_old;
	logic [IDX_W-1:0]  new_idx;

	rc16_term u_term (
		.data_byte    (byte_s1),
		.byte_index   (idx_q),
		.current_term (cur_q),
		.older_term   (older_q),
		.term         (term)
	);

	// a last byte needs a free result register; other bytes always move on
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_comb begin
		if (first_q) begin
			new_cur = {8'b0, byte_s1} + SEED_OFFSET;
			new_old = TERM_ONE;
			new_idx = IDX_FIRST;
		end else begin
			new_cur = term;
			new_old = cur_q;
			new_idx = idx_q + IDX_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			idx_q   <= '0;
			older_q <= TERM_ONE;
			cur_q   <= TERM_ONE;
		end else if (advance) begin
			if (last_s1) begin
				// rearm for the next message
				first_q <= 1'b1;
				idx_q   <= '0;
				older_q <= TERM_ONE;
				cur_q   <= TERM_ONE;
			end else begin
				first_q <= 1'b0;
				idx_q   <= new_idx;
				older_q <= new_old;
				cur_q   <= new_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			checksum_q <= new_cur;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.checksum = checksum_q;

endmodule

`default_nettype wire

/* hdl/rc16_term.sv */
// Next-term datapath: two small products, end-around reduction modulo 2^16-1.
// Depends on rc16_pkg.
`default_nettype none

module rc16_term import rc16_pkg::*; (
	input  logic [DATA_W-1:0] data_byte,
	input  logic [IDX_W-1:0]  byte_index,
	input  logic [TERM_W-1:0] current_term,
	input  logic [TERM_W-1:0] older_term,
	output logic [TERM_W-1:0] term
);

	logic [IDX_W-1:0]  alpha;
	logic [IDX_W-1:0]  beta;
	logic [DATA_W:0]   a_op;
	logic [24:0]       prod_a;
	logic [23:0]       prod_b;
	logic [16:0]       fold_a;
	logic [16:0]       fold_b;
	logic [TERM_W-1:0] res_a;
	logic [TERM_W-1:0] res_b;
	logic              borrow;
	logic [16:0]       diff;
	logic [16:0]       fold_d;

	assign alpha = IDX_W'(byte_index * ALPHA_MUL);
	assign beta  = IDX_W'(byte_index * BETA_MUL);
	assign a_op  = {1'b0, data_byte} + {1'b0, alpha};

	assign prod_a = {16'b0, a_op} * {9'b0, current_term};
	assign prod_b = {16'b0, beta} * {8'b0, older_term};

	// 2^16 = 1 mod 2^16-1: add high part onto low part, one correction
	assign fold_a = {1'b0, prod_a[15:0]} + {8'b0, prod_a[24:16]};
	assign fold_b = {1'b0, prod_b[15:0]} + {9'b0, prod_b[23:16]};
	assign res_a  = (fold_a >= {1'b0, MODULUS}) ? TERM_W'(fold_a - {1'b0, MODULUS})
	                                            : fold_a[15:0];
	assign res_b  = (fold_b >= {1'b0, MODULUS}) ? TERM_W'(fold_b - {1'b0, MODULUS})
	                                            : fold_b[15:0];

	// a negative difference wraps through 2^64, which adds one
	assign borrow = prod_a < {1'b0, prod_b};
	assign diff   = {1'b0, res_a} + {1'b0, MODULUS} - {1'b0, res_b} + {16'b0, borrow};
	assign fold_d = {1'b0, diff[15:0]} + {16'b0, diff[16]};
	assign term   = (fold_d[15:0] == MODULUS) ? '0 : fold_d[15:0];

endmodule

`default_nettype wire

/* hdl/rc16_checker.sv */
// Port-level checks for the recurrence checksum top, attached by bind.
// Depends on recurrence_checksum_16_top.
`default_nettype none

module rc16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] checksum
);

	logic [1:0] pending_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready && in_last;
	assign out_fire = out_valid && out_ready;

	// last bytes taken whose checksum has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_fire && !in_fire) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(checksum))
		else $error("result dropped or changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without a last byte");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two messages in flight");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> checksum != 16'hFFFF)
		else $error("checksum not reduced modulo 65535");

endmodule

bind recurrence_checksum_16_top rc16_checker u_rc16_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last_byte),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.checksum  (out_ch.checksum)
);

`default_nettype wire

/* sim/tb_recurrence_checksum_16_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for recurrence_checksum_16_top: directed rows, then random messages.
// Checksums are predicted by a local model of the three-term recurrence.
// Depends on rc16_pkg, rc16_byte_if, rc16_sum_if and the block itself.

module tb_recurrence_checksum_16_top import rc16_pkg::*;;

	localparam int ITEM_GOAL   = 400;
	localparam int MSG_GOAL    = 50;
	localparam int MAX_GAP     = 11;
	localparam int LONG_HOLD   = 60;
	localparam int BURST_MSGS  = 24;
	localparam int DRAIN_LIMIT = 2000;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
		logic              typed;
		logic [TERM_W-1:0] sum;
	} byte_row_t;

	localparam int N_ROWS = 18;
	localparam byte_row_t DIRECTED [N_ROWS] = '{
		// single-byte messages: checksum is the byte plus 7; then one two-byte message
		'{8'h00, 1'b1, 1'b1, 16'd7},
		'{8'hFF, 1'b1, 1'b1, 16'd262},
		'{8'h80, 1'b1, 1'b1, 16'd135},
		'{8'h01, 1'b1, 1'b1, 16'd8},
		'{8'h55, 1'b0, 1'b0, 16'd0},
		'{8'hAA, 1'b1, 1'b0, 16'd0},
		// second term wraps past the modulus, third one drives the fold below zero
		'{8'd249, 1'b0, 1'b0, 16'd0},
		'{8'd240, 1'b0, 1'b0, 16'd0},
		'{8'h00, 1'b1, 1'b0, 16'd0},
		'{8'hFF, 1'b0, 1'b0, 16'd0},
		'{8'hFF, 1'b0, 1'b0, 16'd0},
		'{8'hFF, 1'b0, 1'b0, 16'd0},
		'{8'hFF, 1'b1, 1'b0, 16'd0},
		'{8'h00, 1'b0, 1'b0, 16'd0},
		'{8'h00, 1'b0, 1'b0, 16'd0},
		'{8'h00, 1'b0, 1'b0, 16'd0},
		'{8'h00, 1'b1, 1'b0, 16'd0},
		// re-armed after the previous message
		'{8'h7F, 1'b1, 1'b1, 16'd134}
	};

	logic clk;
	logic arst_n;

	rc16_byte_if in_ch();
	rc16_sum_if  out_ch();

	recurrence_checksum_16_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow of the request: a checksum typed in by hand for this byte, if any.
	logic              row_typed;
	logic [TERM_W-1:0] row_sum;

	// Predictor state.
	logic              awaiting_first;
	logic [IDX_W-1:0]  byte_pos;
	logic [TERM_W-1:0] prior_term;
	logic [TERM_W-1:0] running_term;

	logic [TERM_W-1:0] expected_sums[$];

	int  mismatches;
	int  sums_checked;
	int  bytes_sent;
	int  msgs_sent;
	int  longest_msg;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200_000;
		$display("Timed out with %0d checksums outstanding", expected_sums.size());
		$display("Mismatches found");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic logic [TERM_W-1:0] fold_term(input logic [DATA_W-1:0] b,
			input logic [IDX_W-1:0] pos, input logic [TERM_W-1:0] cur,
			input logic [TERM_W-1:0] old);
		logic [IDX_W-1:0] alpha;
		logic [IDX_W-1:0] beta;
		int unsigned      prod_a;
		int unsigned      prod_b;
		int unsigned      modv;
		int unsigned      r;
		alpha  = pos * ALPHA_MUL;
		beta   = pos * BETA_MUL;
		modv   = {16'b0, MODULUS};
		prod_a = (int'(b) + int'(alpha)) * int'(cur);
		prod_b = int'(beta) * int'(old);
		if (prod_a >= prod_b) begin
			r = (prod_a - prod_b) % modv;
		end else begin
			// a 64-bit wrap adds one modulo 2^16 - 1
			r = ((prod_a % modv) + 1 + modv - (prod_b % modv)) % modv;
		end
		return r[TERM_W-1:0];
	endfunction

	task automatic rearm_model();
		awaiting_first = 1'b1;
		byte_pos       = '0;
		prior_term     = TERM_ONE;
		running_term   = TERM_ONE;
	endtask

	task automatic absorb_byte(input logic [DATA_W-1:0] b, input logic lst,
			output logic done, output logic [TERM_W-1:0] sum);
		logic [TERM_W-1:0] t;
		if (awaiting_first) begin
			running_term   = {8'b0, b} + SEED_OFFSET;
			prior_term     = TERM_ONE;
			byte_pos       = IDX_FIRST;
			awaiting_first = 1'b0;
		end else begin
			t            = fold_term(b, byte_pos, running_term, prior_term);
			prior_term   = running_term;
			running_term = t;
			byte_pos     = byte_pos + IDX_W'(1);
		end
		done = lst;
		sum  = running_term;
		if (lst)
			rearm_model();
	endtask

	initial rearm_model();

	// Check results first, then predict from the request taken at the same edge.
	always @(posedge clk) begin
		logic              done;
		logic [TERM_W-1:0] sum;
		logic [TERM_W-1:0] want;
		if (arst_n) begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (expected_sums.size() == 0) begin
					flag_mismatch($sformatf("checksum %h with none expected", out_ch.checksum));
				end else begin
					want = expected_sums.pop_front();
					sums_checked++;
					if (out_ch.checksum !== want)
						flag_mismatch($sformatf("checksum got %h want %h",
							out_ch.checksum, want));
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
				absorb_byte(in_ch.data_byte, in_ch.last_byte, done, sum);
				if (done)
					expected_sums.push_back(row_typed ? row_sum : sum);
			end
		end
	end

	function automatic int draw_gap(input bit eager);
		return eager ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic send_byte(input logic [DATA_W-1:0] b, input logic lst,
			input logic typed, input logic [TERM_W-1:0] sum, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= lst;
		row_typed       <= typed;
		row_sum         <= sum;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		bytes_sent++;
		if (lst)
			msgs_sent++;
	endtask

	function automatic logic [DATA_W-1:0] draw_byte();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_message(input int len, input bit eager);
		for (int k = 0; k < len; k++)
			send_byte(draw_byte(), k == len - 1, 1'b0, '0, draw_gap(eager));
		if (len > longest_msg)
			longest_msg = len;
	endtask

	// Drop valid and hold until every outstanding checksum is back or DRAIN_LIMIT is hit.
	task automatic wait_for_drain();
		int n;
		n = 0;
		in_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (expected_sums.size() != 0 && n < DRAIN_LIMIT);
	endtask

	// Result side: random stall per checksum, one long hold on request.
	initial begin : sink_side
		int  stall;
		bit  eager;
		eager = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				eager = !eager;
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = LONG_HOLD;
			end else begin
				stall = draw_gap(eager);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	initial begin : source_side
		int len;
		mismatches      = 0;
		sums_checked    = 0;
		bytes_sent      = 0;
		msgs_sent       = 0;
		longest_msg     = 1;
		hold_req        = 1'b0;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.last_byte = 1'b0;
		out_ch.ready    = 1'b0;
		row_typed       = 1'b0;
		row_sum         = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++)
			send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].typed,
				DIRECTED[r].sum, draw_gap(1'b0));
		wait_for_drain();

		// Back-to-back short messages against a long result hold: fill and stall.
		hold_req = 1'b1;
		for (int m = 0; m < BURST_MSGS; m++)
			send_message(1 + (m % 3), 1'b1);
		wait_for_drain();

		// One message long enough to wrap the byte index.
		send_message($urandom_range(258, 280), $urandom_range(0, 1) == 1);

		while (bytes_sent < ITEM_GOAL || msgs_sent < MSG_GOAL) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			send_message(len, $urandom_range(0, 3) == 0);
		end

		wait_for_drain();
		repeat (SETTLE) @(posedge clk);
		if (expected_sums.size() != 0)
			flag_mismatch($sformatf("%0d checksums never arrived", expected_sums.size()));

		$display("Sent %0d bytes in %0d messages, longest %0d bytes past the index wrap;",
			bytes_sent, msgs_sent, longest_msg);
		$display("compared %0d checksums with random stalls on both sides.", sums_checked);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
